/* src/fbw_pkg.sv */
// ----------------------------------------------------------------------------
// fbw_pkg: shared types and codes of the backward flow warp
// Register indexes, op codes and the request record passed between stages.
// ----------------------------------------------------------------------------
package fbw_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam int SAMPLE_W = 16;
	localparam int OUT_W = 24;
	localparam int OUT_FRAC = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_WARP = 1'b1;

	localparam logic MODE_NEAREST = 1'b0;
	localparam logic MODE_BILINEAR = 1'b1;

	// one memory read issued by the sequencer, tagged for the datapath
	typedef struct packed {
		logic       rd;      // a read is issued this cycle
		logic [1:0] tap;     // 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
		logic       first;   // first tap of a channel
		logic       fin;     // last tap of a channel: result follows
		logic [2:0] chan;
		logic       last;    // last channel of the pixel
		logic       valid;
		logic       bilin;
	} fbw_tag_t;

endpackage

/* src/fbw_mem.sv */
// ----------------------------------------------------------------------------
// fbw_mem: source image store
// Single-port synchronous memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module fbw_mem import fbw_pkg::*; #(
	parameter int ADDR_W = 20
) (
	input  logic                clk,
	input  logic                we,
	input  logic                re,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [SAMPLE_W-1:0] wdata,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* src/fbw_seq.sv */
// ----------------------------------------------------------------------------
// fbw_seq: warp request sequencer
// Computes the sample position, checks bounds and issues memory reads,
// one tap per cycle, for every channel of a pixel that is in bounds.
// ----------------------------------------------------------------------------
module fbw_seq import fbw_pkg::*; #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_CHANNELS = 4,
	parameter int FRAC_BITS = 8,
	parameter int COL_W = 9,
	parameter int ROW_W = 9,
	parameter int CH_W = 2,
	parameter int ADDR_W = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [11:0]          dst_col,
	input  logic [11:0]          dst_row,
	input  logic signed [19:0]   flow_u,
	input  logic signed [19:0]   flow_v,
	input  logic [9:0]           width_q,
	input  logic [9:0]           height_q,
	input  logic [2:0]           nch_q,
	input  logic                 mode_q,
	output logic                 busy,
	output logic                 free_next,
	output logic [ADDR_W-1:0]    raddr,
	output fbw_tag_t             tag,
	output logic [FRAC_BITS-1:0] fx,
	output logic [FRAC_BITS-1:0] fy
);

	localparam int POS_W = 12 + FRAC_BITS + 2;
	localparam int IP_W = POS_W - FRAC_BITS;
	localparam int MAXCH = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;

	logic signed [POS_W-1:0] px, py;
	logic signed [IP_W-1:0]  ixf, iyf, ixr, iyr, ix, iy;
	logic signed [IP_W:0]    wlim, hlim;
	logic [10:0]             wsat, hsat;
	logic [2:0]              nsat;
	logic                    ok;

	logic                    act_q, bil_q, val_q;
	logic [1:0]              tap_q;
	logic [2:0]              ch_q, n_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [FRAC_BITS-1:0]    fx_q, fy_q;
	logic                    ch_end, px_end;
	logic [COL_W-1:0]        c;
	logic [ROW_W-1:0]        r;

	always_comb begin
		px = $signed({2'b00, dst_col, {FRAC_BITS{1'b0}}}) + POS_W'(flow_u);
		py = $signed({2'b00, dst_row, {FRAC_BITS{1'b0}}}) + POS_W'(flow_v);
		ixf = px[POS_W-1:FRAC_BITS];
		iyf = py[POS_W-1:FRAC_BITS];
		// round half away from zero on the magnitude
		ixr = px[POS_W-1] ? -IP_W'((-px + POS_W'(2**(FRAC_BITS-1))) >>> FRAC_BITS)
			: IP_W'((px + POS_W'(2**(FRAC_BITS-1))) >>> FRAC_BITS);
		iyr = py[POS_W-1] ? -IP_W'((-py + POS_W'(2**(FRAC_BITS-1))) >>> FRAC_BITS)
			: IP_W'((py + POS_W'(2**(FRAC_BITS-1))) >>> FRAC_BITS);
		wsat = (width_q == 10'd0) ? 11'd1 : (32'(width_q) > MAX_WIDTH) ? 11'(MAX_WIDTH)
			: 11'(width_q);
		hsat = (height_q == 10'd0) ? 11'd1 : (32'(height_q) > MAX_HEIGHT) ? 11'(MAX_HEIGHT)
			: 11'(height_q);
		nsat = (nch_q == 3'd0) ? 3'd1 : (32'(nch_q) > MAXCH) ? 3'(MAXCH) : nch_q;
		ix = (mode_q == MODE_BILINEAR) ? ixf : ixr;
		iy = (mode_q == MODE_BILINEAR) ? iyf : iyr;
		wlim = (mode_q == MODE_BILINEAR) ? $signed({1'b0, IP_W'(wsat)}) - (IP_W+1)'(1)
			: $signed({1'b0, IP_W'(wsat)});
		hlim = (mode_q == MODE_BILINEAR) ? $signed({1'b0, IP_W'(hsat)}) - (IP_W+1)'(1)
			: $signed({1'b0, IP_W'(hsat)});
		ok = !ix[IP_W-1] && !iy[IP_W-1] && ($signed({ix[IP_W-1], ix}) < wlim)
			&& ($signed({iy[IP_W-1], iy}) < hlim);
	end

	assign ch_end = !bil_q || !val_q || tap_q == 2'd3;
	assign px_end = ch_end && (ch_q + 3'd1 == n_q);
	assign busy = act_q;
	assign free_next = !act_q || px_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			tap_q <= 2'd0;
			ch_q <= 3'd0;
		end else if (go) begin
			act_q <= 1'b1;
			tap_q <= 2'd0;
			ch_q <= 3'd0;
		end else if (act_q) begin
			if (px_end) begin
				act_q <= 1'b0;
			end else if (ch_end) begin
				tap_q <= 2'd0;
				ch_q <= ch_q + 3'd1;
			end else begin
				tap_q <= tap_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			bil_q <= mode_q;
			val_q <= ok;
			n_q <= nsat;
			col_q <= COL_W'(ix);
			row_q <= ROW_W'(iy);
			fx_q <= px[FRAC_BITS-1:0];
			fy_q <= py[FRAC_BITS-1:0];
		end
	end

	always_comb begin
		c = col_q + COL_W'(tap_q[0]);
		r = row_q + ROW_W'(tap_q[1]);
		raddr = ADDR_W'({r, c, CH_W'(ch_q)});
		tag.rd = act_q && val_q;
		tag.tap = tap_q;
		tag.first = tap_q == 2'd0;
		tag.fin = act_q && ch_end;
		tag.chan = ch_q;
		tag.last = px_end;
		tag.valid = val_q;
		tag.bilin = bil_q;
		fx = fx_q;
		fy = fy_q;
	end

endmodule

/* src/fbw_dp.sv */
// ----------------------------------------------------------------------------
// fbw_dp: interpolation datapath
// Weights each returned sample and sums the four taps of a bilinear channel,
// then rounds and saturates; nearest passes the sample; result is registered.
// ----------------------------------------------------------------------------
module fbw_dp import fbw_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fbw_tag_t             tag_s1,
	input  logic [FRAC_BITS-1:0] fx_s1,
	input  logic [FRAC_BITS-1:0] fy_s1,
	input  logic [SAMPLE_W-1:0]  rdata,
	output logic                 done,
	output logic [1:0]           out_channel,
	output logic [OUT_W-1:0]     out_value,
	output logic                 out_valid,
	output logic                 out_last
);

	localparam int WT_W = 2 * FRAC_BITS + 2;
	localparam int ACC_W = SAMPLE_W + WT_W;
	localparam int SH = 2 * FRAC_BITS - OUT_FRAC;

	logic [FRAC_BITS:0] wx, wy;
	logic [WT_W-1:0]    wt, wt_s2;
	logic [SAMPLE_W-1:0] smp_s2;
	logic [SAMPLE_W-1:0] smp_s2_hold_q;
	fbw_tag_t           tag_s2, tag_s3;
	logic [ACC_W-1:0]   prod_s3, acc_q, sum;
	logic [ACC_W:0]     rnd;
	logic [OUT_W-1:0]   val;

	always_comb begin
		wx = tag_s1.tap[0] ? {1'b0, fx_s1} : (FRAC_BITS+1)'(2**FRAC_BITS) - {1'b0, fx_s1};
		wy = tag_s1.tap[1] ? {1'b0, fy_s1} : (FRAC_BITS+1)'(2**FRAC_BITS) - {1'b0, fy_s1};
		wt = WT_W'(wx) * WT_W'(wy);
	end

	always_ff @(posedge clk) begin
		wt_s2 <= wt;
		smp_s2 <= rdata;
		prod_s3 <= ACC_W'(smp_s2) * ACC_W'(wt_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			done <= 1'b0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			done <= tag_s3.fin;
		end
	end

	always_comb begin
		sum = (tag_s3.first ? '0 : acc_q) + prod_s3;
		if (SH > 0) begin
			rnd = ({1'b0, sum} + (ACC_W+1)'(2**SH >> 1)) >> SH;
		end else begin
			rnd = {1'b0, sum} << (-SH);
		end
		if (!tag_s3.valid) begin
			val = '0;
		end else if (tag_s3.bilin) begin
			val = (rnd > (ACC_W+1)'(2**OUT_W - 1)) ? '1 : OUT_W'(rnd);
		end else begin
			val = {smp_s2_hold_q, {OUT_FRAC{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		smp_s2_hold_q <= smp_s2;
		acc_q <= sum;
		if (tag_s3.fin) begin
			out_channel <= tag_s3.chan[1:0];
			out_value <= val;
			out_valid <= tag_s3.valid;
			out_last <= tag_s3.last;
		end
	end

endmodule

/* src/flow_backward_warp.sv */
// Backward flow warp with a single-port source image memory.
// A channel's result passes stages s1, s2 and s3 into the output registers.
// Nearest reads one tap per channel and bilinear four, for in-bounds pixels
// (one read per cycle on the image memory); a load is a single write.
// Results cannot be stalled. Reset restores all configuration registers;
// image contents are undefined until written.
// ----------------------------------------------------------------------------
// flow_backward_warp: top level
// Configuration registers, load path and the warp pipeline around the memory.
// ----------------------------------------------------------------------------
module flow_backward_warp import fbw_pkg::*; #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int MAX_CHANNELS = 4,
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [8:0]           src_col,
	input  logic [8:0]           src_row,
	input  logic [1:0]           src_channel,
	input  logic [15:0]          sample_value,
	input  logic [11:0]          dst_col,
	input  logic [11:0]          dst_row,
	input  logic signed [19:0]   flow_u,
	input  logic signed [19:0]   flow_v,
	output logic                 strobe,
	output logic [1:0]           out_channel,
	output logic [23:0]          out_value,
	output logic                 out_valid,
	output logic                 out_last
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ADDR_W = COL_W + ROW_W + CH_W;

	logic [9:0] width_q, height_q;
	logic [2:0] nch_q;
	logic       mode_q;

	logic                 seq_busy, free_next, go, ld, wr_ok;
	logic [ADDR_W-1:0]    raddr, maddr;
	fbw_tag_t             tag, tag_s1;
	logic [FRAC_BITS-1:0] fx, fy, fx_s1, fy_s1;
	logic [SAMPLE_W-1:0]  rdata;
	logic                 wr_s1;
	logic [ADDR_W-1:0]    waddr_s1;
	logic [SAMPLE_W-1:0]  wdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 10'd512;
			height_q <= 10'd512;
			nch_q <= 3'd1;
			mode_q <= MODE_NEAREST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:    width_q <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				REG_CHANNELS: nch_q <= cfg_data[2:0];
				REG_MODE:     mode_q <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// the sequencer frees itself on its final read, so busy is low during that read
	assign busy = seq_busy && !free_next;
	assign go = start && !busy && op == OP_WARP;
	assign ld = start && !busy && op == OP_LOAD;
	assign wr_ok = 32'(src_col) < MAX_WIDTH && 32'(src_row) < MAX_HEIGHT
		&& 32'(src_channel) < MAX_CHANNELS;

	fbw_seq #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS),
		.FRAC_BITS(FRAC_BITS), .COL_W(COL_W), .ROW_W(ROW_W), .CH_W(CH_W), .ADDR_W(ADDR_W)
	) u_seq (
		.clk, .arst_n, .go, .dst_col, .dst_row, .flow_u, .flow_v,
		.width_q, .height_q, .nch_q, .mode_q,
		.busy(seq_busy), .free_next, .raddr, .tag, .fx, .fy
	);

	// a load may be taken on the final read of a warp, so its write lands in the
	// next cycle, when the sequencer is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= ld && wr_ok;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= ADDR_W'({ROW_W'(src_row), COL_W'(src_col), CH_W'(src_channel)});
		wdata_s1 <= sample_value;
	end

	fbw_tag_t tag_go;
	always_comb begin
		tag_go = tag;
		if (!seq_busy || (free_next && go)) begin
			tag_go = tag;
		end
		maddr = wr_s1 ? waddr_s1 : raddr;
	end

	fbw_mem #(.ADDR_W(ADDR_W)) u_mem (
		.clk, .we(wr_s1), .re(tag.rd), .addr(maddr), .wdata(wdata_s1), .rdata
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_go;
		end
	end

	always_ff @(posedge clk) begin
		fx_s1 <= fx;
		fy_s1 <= fy;
	end

	fbw_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .tag_s1, .fx_s1, .fy_s1, .rdata,
		.done(strobe), .out_channel, .out_value, .out_valid, .out_last
	);

endmodule
